FILE: rtl/ssba_pkg.sv
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Shared field widths, operation and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssba_pkg;

    // Field widths of the request and result transactions.
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 10;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SECTOR_W = 13;

    // Width of the usable slot count register and its reset value.
    localparam int CNT_W     = 11;
    localparam int CNT_RESET = 1024;

    // Internal slot index wide enough for any count the register can hold.
    localparam int IDX_W = CNT_W;

    // Occupancy map row: 32 slots per memory word.
    localparam int MAP_W = 32;
    localparam int LOG_W = 5;

    // Request operations.
    localparam logic [OP_W-1:0] OP_SWAP_OUT = 1'b0;
    localparam logic [OP_W-1:0] OP_SWAP_IN  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;     // write a zero row and step the row pointer
        logic accept;     // capture the request
        logic rd_en;      // read the current map row
        logic scan_next;  // move the scan to the next row
        logic commit;     // write back the updated row
        logic emit;       // load one sector result
        logic emit_err;   // load the error result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;   // clearing pass is on the last row
        logic is_in;      // captured request is a swap in
        logic row_past;   // current row lies wholly beyond the usable count
        logic found;      // free slot found, or swap-in slot is valid
        logic out_free;   // output register can take a result this cycle
        logic emit_last;  // next sector result is the final one
    } t_sts;

endpackage

FILE: rtl/ssba_ctrl.sv
// ----------------------------------------------------------------------------
// Swap slot allocator controller
// Sequences the clearing pass, the row-by-row map scan, the row write-back
// and the emission of sector or error results.
// ----------------------------------------------------------------------------
module ssba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  ssba_pkg::t_sts i_sts,
    output ssba_pkg::t_cmd o_cmd
);
    import ssba_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERROR = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register; reset starts the clearing pass over the map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.is_in) begin
                    if (i_sts.found) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_ERROR;
                    end
                end else if (i_sts.row_past) begin
                    n_state = S_ERROR;
                end else if (i_sts.found) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERROR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/ssba_dpath.sv
// ----------------------------------------------------------------------------
// Swap slot allocator datapath
// Holds the occupancy map memory, the usable count register, the scan
// pointers, the first-free search and the output register.
// ----------------------------------------------------------------------------
module ssba_dpath #(
    parameter int MAX_SLOTS    = 1024,
    parameter int PAGE_SECTORS = 8,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ssba_pkg::CNT_W-1:0]      i_cfg_wr_data,
    input  logic [ssba_pkg::OP_W-1:0]       i_op,
    input  logic [ssba_pkg::SLOT_W-1:0]     i_slot,
    input  logic [ssba_pkg::ADDR_W-1:0]     i_frame,
    input  ssba_pkg::t_cmd                  i_cmd,
    output ssba_pkg::t_sts                  o_sts,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [ssba_pkg::STATUS_W-1:0]   o_m_status,
    output logic [ssba_pkg::SLOT_W-1:0]     o_m_slot,
    output logic                            o_m_is_write,
    output logic [ssba_pkg::SECTOR_W-1:0]   o_m_sector,
    output logic [ssba_pkg::ADDR_W-1:0]     o_m_addr,
    output logic                            o_m_last
);
    import ssba_pkg::*;

    // Only slots below the largest count the register can hold are reachable.
    localparam int USED   = (MAX_SLOTS < (1 << CNT_W)) ? MAX_SLOTS : (1 << CNT_W);
    localparam int ROWS   = (USED + MAP_W - 1) / MAP_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_CW = $clog2(ROWS + 1);
    localparam int SIDX_W = (PAGE_SECTORS > 1) ? $clog2(PAGE_SECTORS) : 1;
    localparam int N_W    = CNT_W + 1;

    // Occupancy map, one bit per slot, 1 = taken.
    logic [MAP_W-1:0]  r_map [ROWS];
    logic [MAP_W-1:0]  r_rdata;

    logic [CNT_W-1:0]  r_cnt;
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_slot;
    logic [ADDR_W-1:0] r_addr;
    logic [ROW_CW-1:0] r_row;
    logic [ROW_CW-1:0] r_hint;
    logic [SIDX_W-1:0] r_sidx;
    logic              r_m_valid;

    logic [N_W-1:0]    w_n;
    logic [N_W-1:0]    w_base;
    logic [N_W-1:0]    w_rem;
    logic              w_past;
    logic              w_is_in;
    logic              w_free_found;
    logic [LOG_W-1:0]  w_free_idx;
    logic [LOG_W-1:0]  w_bit_sel;
    logic [LOG_W-1:0]  w_pos;
    logic              w_in_ok;
    logic [MAP_W-1:0]  w_onehot;
    logic [MAP_W-1:0]  w_wdata;
    logic              w_wr_en;
    logic              w_out_free;
    logic              w_emit_last;

    // Usable slot count, capped at what the map holds.
    always_comb begin
        if (N_W'(r_cnt) > N_W'(USED)) begin
            w_n = N_W'(USED);
        end else begin
            w_n = N_W'(r_cnt);
        end
    end

    // Position of the current row against the usable count.
    assign w_base  = N_W'({r_row, {LOG_W{1'b0}}});
    assign w_past  = (w_base >= w_n);
    assign w_rem   = w_n - w_base;
    assign w_is_in = (r_op == OP_SWAP_IN);

    // Lowest free slot in the row, ignoring slots at or above the count.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (!r_rdata[b] && (N_W'(b) < w_rem)) begin
                w_free_found = 1'b1;
                w_free_idx   = LOG_W'(b);
            end
        end
    end

    // Swap-in check: the slot must be in range and taken.
    assign w_bit_sel = r_slot[LOG_W-1:0];
    assign w_in_ok   = (N_W'(r_slot) < w_n) && r_rdata[w_bit_sel];

    // Row write-back data.
    assign w_pos    = w_is_in ? w_bit_sel : w_free_idx;
    assign w_onehot = MAP_W'(1) << w_pos;
    always_comb begin
        if (i_cmd.clr_wr) begin
            w_wdata = '0;
        end else if (w_is_in) begin
            w_wdata = r_rdata & ~w_onehot;
        end else begin
            w_wdata = r_rdata | w_onehot;
        end
    end
    assign w_wr_en = i_cmd.clr_wr || i_cmd.commit;

    // Map memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_map[r_row[ROW_AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_map[r_row[ROW_AW-1:0]];
        end
    end

    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_emit_last = (r_sidx == SIDX_W'(PAGE_SECTORS - 1));

    // Status to the controller.
    always_comb begin
        o_sts.clr_done  = (r_row == ROW_CW'(ROWS - 1));
        o_sts.is_in     = w_is_in;
        o_sts.row_past  = w_past;
        o_sts.found     = w_is_in ? w_in_ok : (w_free_found && !w_past);
        o_sts.out_free  = w_out_free;
        o_sts.emit_last = w_emit_last;
    end

    // Control registers: count, row pointer, scan hint and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= CNT_W'(CNT_RESET);
            r_row     <= '0;
            r_hint    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cnt <= i_cfg_wr_data;
            end
            if (i_cmd.clr_wr) begin
                r_row <= r_row + 1'b1;
            end else if (i_cmd.accept) begin
                if (i_op == OP_SWAP_IN) begin
                    r_row <= ROW_CW'(i_slot >> LOG_W);
                end else begin
                    r_row <= r_hint;
                end
            end else if (i_cmd.scan_next) begin
                r_row <= r_row + 1'b1;
                // A completely full row at the hint moves the hint past it.
                if ((&r_rdata) && (r_row == r_hint)) begin
                    r_hint <= r_row + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (!w_is_in) begin
                    r_hint <= r_row;
                end else if (r_row < r_hint) begin
                    r_hint <= r_row;
                end
            end
            if (i_cmd.emit || i_cmd.emit_err) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Request payload and sector sequencing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_slot <= IDX_W'(i_slot);
            r_addr <= i_frame;
            r_sidx <= '0;
        end else if (i_cmd.commit && !w_is_in) begin
            r_slot <= IDX_W'({r_row, w_free_idx});
        end else if (i_cmd.emit) begin
            r_addr <= r_addr + ADDR_W'(SECTOR_BYTES);
            r_sidx <= r_sidx + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_m_status   <= ST_OK;
            o_m_slot     <= r_slot[SLOT_W-1:0];
            o_m_is_write <= !w_is_in;
            o_m_sector   <= SECTOR_W'(32'(r_slot) * 32'(PAGE_SECTORS) + 32'(r_sidx));
            o_m_addr     <= r_addr;
            o_m_last     <= w_emit_last;
        end else if (i_cmd.emit_err) begin
            o_m_status   <= w_is_in ? ST_BAD_SLOT : ST_NO_FREE;
            o_m_slot     <= w_is_in ? r_slot[SLOT_W-1:0] : '0;
            o_m_is_write <= 1'b0;
            o_m_sector   <= '0;
            o_m_addr     <= '0;
            o_m_last     <= 1'b1;
        end
    end

    assign o_m_tvalid = r_m_valid;

endmodule

FILE: rtl/swap_slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit allocator over a one-bit-per-slot map of page-sized swap slots,
// emitting one disk command per sector of each page swapped out or in.
//
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tuser: operation; tdata: slot, frame
// m         out  o_m_tvalid/i_m_tready  tuser: status, is_write; tdata; tlast
// cfg       in   i_cfg_wr_en            i_cfg_wr_data: slot_count
//
// A request is accepted, then each 32-slot map row visited is read and
// evaluated, and then one result per sector is emitted (or one error result).
// Swap in visits one row; swap out scans from the lowest row that may still
// hold a free slot up to the row where one is found or the count is passed.
// After reset a clearing pass zeroes the ceil(min(MAX_SLOTS, 2048) / 32) map
// rows; no request is accepted meanwhile.
// A stalled output holds the sequencer; a new request is taken while the
// final result of the previous one waits in the output register.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_top #(
    parameter int MAX_SLOTS    = 1024,
    parameter int PAGE_SECTORS = 8,
    parameter int SECTOR_BYTES = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ssba_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [47:0]                i_s_tdata,   // slot [9:0], frame_address [41:10]
    input  logic [0:0]                 i_s_tuser,   // operation [0]
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [55:0]                o_m_tdata,   // slot_used [9:0], sector_number [22:10],
                                                    // memory_address [54:23]
    output logic [2:0]                 o_m_tuser,   // status [1:0], is_write [2]
    output logic                       o_m_tlast    // last
);
    import ssba_pkg::*;

    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [STATUS_W-1:0] w_status;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_is_write;
    logic [SECTOR_W-1:0] w_sector;
    logic [ADDR_W-1:0]   w_addr;

    // Sequencer.
    ssba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Map, pointers and output register.
    ssba_dpath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .PAGE_SECTORS (PAGE_SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (i_s_tuser),
        .i_slot        (i_s_tdata[9:0]),
        .i_frame       (i_s_tdata[41:10]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_status    (w_status),
        .o_m_slot      (w_slot),
        .o_m_is_write  (w_is_write),
        .o_m_sector    (w_sector),
        .o_m_addr      (w_addr),
        .o_m_last      (o_m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign o_m_tdata = {1'b0, w_addr, w_sector, w_slot};
    assign o_m_tuser = {w_is_write, w_status};

endmodule

FILE: rtl/ssba_checker.sv
// ----------------------------------------------------------------------------
// Swap slot allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ssba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] i_m_tdata,
    input logic [2:0]  i_m_tuser,
    input logic        i_m_tlast
);
    import ssba_pkg::*;

    // No request is taken in the first cycle after reset: the map is clearing.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_s_tready)
        else $error("request accepted during map clearing");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast)))
        else $error("stalled result changed");

    // Sector results follow back to back with consecutive sector numbers.
    a_sector_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && !i_m_tlast) |=> (i_m_tvalid
            && (i_m_tdata[22:10] == $past(i_m_tdata[22:10]) + 13'd1)))
        else $error("sector sequence broken");

    // An error result is a single final transaction with cleared command fields.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (i_m_tuser[1:0] != ST_OK)) |-> (i_m_tlast && !i_m_tuser[2]
            && (i_m_tdata[54:10] == 45'd0)))
        else $error("malformed error result");

endmodule

bind swap_slot_bitmap_allocator_top ssba_checker u_ssba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator testbench
// Drives swap-out and swap-in requests through the slave stream. It keeps
// its own copy of the slot occupancy map and the usable slot count, and
// predicts every sector command and error result from them. Each result
// transaction on the master stream is checked field by field, in order,
// against the oldest prediction. The run covers several slot count settings,
// fills every usable slot, and applies random idling and back-pressure on
// both streams.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ssba_pkg::*;

    localparam int MAX_SLOTS    = 1024;
    localparam int PAGE_SECTORS = 8;
    localparam int SECTOR_BYTES = 512;

    // One request as queued by the stimulus; take_held asks the driver to
    // aim a swap in at a slot that is currently taken.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] frame;
        bit                take_held;
    } t_swap_req;

    // One sector command or error result.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_used;
        logic                is_write;
        logic [SECTOR_W-1:0] sector;
        logic [ADDR_W-1:0]   mem_addr;
        logic                last;
    } t_sector_cmd;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wr_data = '0;
    logic                i_s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [47:0]         i_s_tdata     = '0;  // slot [9:0], frame_address [41:10]
    logic [0:0]          i_s_tuser     = '0;  // operation [0]
    logic                o_m_tvalid;
    logic                i_m_tready    = 1'b0;
    logic [55:0]         o_m_tdata;           // slot_used [9:0], sector_number [22:10],
                                              // memory_address [54:23]
    logic [2:0]          o_m_tuser;           // status [1:0], is_write [2]
    logic                o_m_tlast;           // last

    // Predictor state: occupancy map and usable slot count register.
    bit                  slot_busy [MAX_SLOTS];
    logic [CNT_W-1:0]    slot_limit = CNT_W'(CNT_RESET);

    t_swap_req           queued_reqs [$];
    t_sector_cmd         due_cmds [$];
    t_swap_req           cur_req;

    // Idling controls, set per phase by the stimulus process.
    bit                  sender_idles   = 1'b1;
    bit                  receiver_idles = 1'b1;
    int                  long_hold_len  = 0;
    int                  gap_left       = 0;
    int                  stall_left     = 0;

    int                  n_requests   = 0;
    int                  n_results    = 0;
    int                  n_err_results = 0;
    int                  n_cfg_writes = 0;
    int                  n_mismatch   = 0;

    swap_slot_bitmap_allocator_top #(
        .MAX_SLOTS    (MAX_SLOTS),
        .PAGE_SECTORS (PAGE_SECTORS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int usable_slots();
        return (int'(slot_limit) < MAX_SLOTS) ? int'(slot_limit) : MAX_SLOTS;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        if ($urandom_range(99) < 80)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Expected commands for every sector of one page.
    function automatic void queue_sector_cmds(logic [SLOT_W-1:0] slot,
                                              logic [ADDR_W-1:0] frame, logic wr);
        t_sector_cmd c;
        for (int s = 0; s < PAGE_SECTORS; s++) begin
            c.status    = ST_OK;
            c.slot_used = slot;
            c.is_write  = wr;
            c.sector    = SECTOR_W'(int'(slot) * PAGE_SECTORS + s);
            c.mem_addr  = frame + ADDR_W'(s * SECTOR_BYTES);
            c.last      = (s == PAGE_SECTORS - 1);
            due_cmds.push_back(c);
        end
    endfunction

    // First-fit allocation for swap out, range and occupancy check for swap in.
    function automatic void predict_slot_request(t_swap_req r);
        int          usable;
        int          pick;
        t_sector_cmd err;
        usable = usable_slots();
        pick   = -1;
        err    = '0;
        err.last = 1'b1;
        if (r.op == OP_SWAP_OUT) begin
            for (int k = 0; k < usable && pick < 0; k++)
                if (!slot_busy[k])
                    pick = k;
            if (pick >= 0) begin
                slot_busy[pick] = 1'b1;
                queue_sector_cmds(SLOT_W'(pick), r.frame, 1'b1);
            end else begin
                err.status = ST_NO_FREE;
                due_cmds.push_back(err);
            end
        end else if (int'(r.slot) >= usable || !slot_busy[r.slot]) begin
            err.status    = ST_BAD_SLOT;
            err.slot_used = r.slot;
            due_cmds.push_back(err);
        end else begin
            queue_sector_cmds(r.slot, r.frame, 1'b0);
            slot_busy[r.slot] = 1'b0;
        end
    endfunction

    // Request driver: predicts each accepted transaction, then offers the
    // next queued request once any idle gap has run out.
    always @(posedge i_clk) begin : request_driver
        logic next_valid;
        int   held_slots [$];
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                predict_slot_request(cur_req);
                n_requests++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_reqs.size() != 0) begin
                    cur_req = queued_reqs.pop_front();
                    // Aim at a taken slot within the usable range, if any.
                    if (cur_req.take_held) begin
                        held_slots.delete();
                        for (int k = 0; k < usable_slots(); k++)
                            if (slot_busy[k])
                                held_slots.push_back(k);
                        if (held_slots.size() != 0)
                            cur_req.slot = SLOT_W'(
                                held_slots[$urandom_range(held_slots.size() - 1)]);
                    end
                    i_s_tdata  <= {6'b0, cur_req.frame, cur_req.slot};
                    i_s_tuser  <= cur_req.op;
                    next_valid = 1'b1;
                    gap_left   = (sender_idles && $urandom_range(99) < 30) ? idle_gap() : 0;
                end
            end
            i_s_tvalid <= next_valid;
        end
    end

    // Result monitor: checks each result transaction and drives back-pressure.
    always @(posedge i_clk) begin : result_monitor
        t_sector_cmd got;
        t_sector_cmd want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.status    = o_m_tuser[1:0];
                got.is_write  = o_m_tuser[2];
                got.slot_used = o_m_tdata[9:0];
                got.sector    = o_m_tdata[22:10];
                got.mem_addr  = o_m_tdata[54:23];
                got.last      = o_m_tlast;
                n_results++;
                if (due_cmds.size() == 0) begin
                    $display(
                        "%0t: unexpected st=%0d slot=%0d wr=%0b sec=%0d addr=%h last=%0b",
                        $realtime, got.status, got.slot_used, got.is_write,
                        got.sector, got.mem_addr, got.last);
                    n_mismatch++;
                end else begin
                    want = due_cmds.pop_front();
                    if (want.status != ST_OK)
                        n_err_results++;
                    if (got !== want) begin
                        $display(
                            "%0t: expected st=%0d slot=%0d wr=%0b sec=%0d addr=%h last=%0b",
                            $realtime, want.status, want.slot_used, want.is_write,
                            want.sector, want.mem_addr, want.last);
                        $display(
                            "%0t: actual   st=%0d slot=%0d wr=%0b sec=%0d addr=%h last=%0b",
                            $realtime, got.status, got.slot_used, got.is_write,
                            got.sector, got.mem_addr, got.last);
                        n_mismatch++;
                    end
                end
            end
            // A long hold requested by the stimulus overrides random stalls.
            if (long_hold_len > 0) begin
                stall_left    = long_hold_len;
                long_hold_len = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (receiver_idles && $urandom_range(99) < 25) begin
                stall_left = idle_gap() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Waits until every request has been taken and every result has arrived.
    task automatic drain_all();
        while (queued_reqs.size() != 0 || i_s_tvalid || due_cmds.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_slot_count(logic [CNT_W-1:0] value);
        drain_all();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        slot_limit    = value;
        n_cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic queue_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                 logic [ADDR_W-1:0] frame, bit take_held);
        t_swap_req r;
        r.op        = op;
        r.slot      = slot;
        r.frame     = frame;
        r.take_held = take_held;
        queued_reqs.push_back(r);
    endtask

    // Random mix: swap outs, swap ins of taken slots, and swap ins of any slot.
    task automatic queue_random(int count);
        int                pick;
        logic [ADDR_W-1:0] frame;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(99);
            frame = $urandom;
            if ($urandom_range(9) == 0)
                frame = $urandom_range(1) ? '1 : '0;
            if (pick < 50)
                queue_request(OP_SWAP_OUT, SLOT_W'($urandom), frame, 1'b0);
            else if (pick < 85)
                queue_request(OP_SWAP_IN, SLOT_W'($urandom), frame, 1'b1);
            else
                queue_request(OP_SWAP_IN, SLOT_W'($urandom), frame, 1'b0);
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset slot count.
        queue_request(OP_SWAP_IN,  10'd0,    32'h0000_0000, 1'b0);
        queue_request(OP_SWAP_IN,  10'd1023, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_SWAP_OUT, 10'd1023, 32'h0000_0000, 1'b0);
        queue_request(OP_SWAP_OUT, 10'd0,    32'hFFFF_FFFF, 1'b0);
        queue_request(OP_SWAP_OUT, 10'h2AA,  32'hFFFF_F1FF, 1'b0);
        queue_request(OP_SWAP_IN,  10'd1,    32'h1234_5678, 1'b0);
        queue_request(OP_SWAP_IN,  10'd1,    32'h1234_5678, 1'b0);
        queue_request(OP_SWAP_OUT, 10'h155,  32'h8000_0000, 1'b0);
        queue_request(OP_SWAP_IN,  10'h2AA,  32'h5555_5555, 1'b0);
        queue_request(OP_SWAP_IN,  10'h155,  32'hAAAA_AAAA, 1'b0);

        // No usable slots at all: every request fails.
        set_slot_count(11'd0);
        queue_request(OP_SWAP_OUT, 10'd0, 32'h0000_1000, 1'b0);
        queue_request(OP_SWAP_IN,  10'd0, 32'h0000_2000, 1'b0);

        // Lowered count: the taken slot above it is kept but not accepted.
        set_slot_count(11'd2);
        queue_request(OP_SWAP_OUT, 10'd0, 32'h0000_3000, 1'b0);
        queue_request(OP_SWAP_IN,  10'd2, 32'h0000_4000, 1'b0);
        queue_request(OP_SWAP_IN,  10'd1, 32'h0000_5000, 1'b0);
        queue_request(OP_SWAP_OUT, 10'd0, 32'h0000_6000, 1'b0);

        // Largest register value: usable count is capped at the map size.
        set_slot_count(11'h7FF);
        queue_request(OP_SWAP_IN,  10'd2, 32'h7FFF_FFFF, 1'b0);
        queue_request(OP_SWAP_OUT, 10'd0, 32'hDEAD_BE00, 1'b0);

        // Fill every usable slot without idling, then overflow.
        set_slot_count(11'd96);
        drain_all();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int n = 0; n < 96; n++)
            queue_request(OP_SWAP_OUT, SLOT_W'($urandom), $urandom, 1'b0);
        queue_request(OP_SWAP_IN,  10'd95, 32'h0BAD_F00D, 1'b0);
        queue_request(OP_SWAP_IN,  10'd64, 32'hFFFF_FE00, 1'b0);
        queue_request(OP_SWAP_OUT, 10'd0,  32'h0101_0101, 1'b0);
        drain_all();

        // Receiver holds off for a long stretch while requests keep coming.
        receiver_idles = 1'b1;
        long_hold_len  = 400;
        queue_random(40);
        drain_all();
        sender_idles = 1'b1;
        queue_random(20);

        // Random phases over several slot count settings.
        set_slot_count(11'd40);
        queue_random(40);
        set_slot_count(11'h7FF);
        queue_random(40);
        set_slot_count(11'd1);
        queue_random(20);
        set_slot_count(11'd97);
        queue_random(40);
        set_slot_count(11'd1024);
        queue_random(40);

        drain_all();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d requests with %0d result transactions (%0d error results),",
                 n_requests, n_results, n_err_results);
        $display("over %0d slot count writes, a filled usable range and a long hold-off.",
                 n_cfg_writes);
        if (n_mismatch == 0 && due_cmds.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung run.
    initial begin
        #20_000_000;
        $display("%0t: timeout with %0d results outstanding", $realtime, due_cmds.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/ssba_pkg.sv
rtl/ssba_ctrl.sv
rtl/ssba_dpath.sv
rtl/swap_slot_bitmap_allocator_top.sv
rtl/ssba_checker.sv
tb/sv/testbench.sv
